/* hw/rtl/stcd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stcd_pkg
// Shared constants and types of the stationary track detector.
// ---------------------------------------------------------------------------
package stcd_pkg;

    localparam int MAX_TRACKS = 8;
    localparam int MAX_POINTS = 32;
    localparam int TRK_W      = 3;
    localparam int SLOT_W     = 5;
    localparam int CNT_W      = 6;
    localparam int ADDR_W     = TRK_W + SLOT_W;
    localparam int DEPTH      = MAX_TRACKS * MAX_POINTS;
    localparam int ENTRY_W    = 64;

    localparam logic [1:0] CFG_TRAIL  = 2'd0;
    localparam logic [1:0] CFG_WINDOW = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;
    localparam logic [1:0] CFG_DIM    = 2'd3;

    localparam logic OP_REPORT = 1'b0;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               win;
    } t_pt;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_PRUNE_RD = 9'b000000010,
        ST_PRUNE_CK = 9'b000000100,
        ST_DUP_RD   = 9'b000001000,
        ST_DUP_CK   = 9'b000010000,
        ST_APPEND   = 9'b000100000,
        ST_LOAD     = 9'b001000000,
        ST_DRAIN    = 9'b010000000,
        ST_FIN      = 9'b100000000
    } t_state;

endpackage

/* hw/rtl/stcd_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stcd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module stcd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hw/rtl/stcd_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stcd_cell
// One stage of the point chain: holds a position and its in-window flag.
// ---------------------------------------------------------------------------
module stcd_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  stcd_pkg::t_pt i_pt,
    output stcd_pkg::t_pt o_pt
);
    import stcd_pkg::*;

    t_pt r_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt.win <= 1'b0;
        end else if (i_shift) begin
            r_pt.win <= i_pt.win;
        end
        if (i_shift) begin
            r_pt.x <= i_pt.x;
            r_pt.y <= i_pt.y;
        end
    end

    assign o_pt = r_pt;
endmodule

/* hw/rtl/stationary_track_detector_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stationary_track_detector_core
// Per-track position history with an exact centroid spread test.
// ---------------------------------------------------------------------------
// Requests enter on the s-side stream: tuser carries op and has_position,
// tdata carries track, x, y and time. One result per request leaves on the
// m-side stream. Registers are written on the config channel, which is always
// ready; the user must write them only while the block is idle, as the block
// itself does not enforce it. A request runs through the expiry check, which
// reads and checks each expired point and the first kept one; the duplicate
// check and append; the load of the track's 32 history slots from the point
// RAM into the chain of cells; the drain of the chain through the spread
// pipeline; and the hand-over of the result, after which the block returns to
// idle before the next request is accepted. The single read port of the point
// RAM and the 32-cell chain set the pace. One request is processed at a time.
// Reset empties all histories and loads the register defaults; the point RAM
// is not cleared. A stalled receiver holds the result in the output register;
// the next request may be accepted meanwhile and waits in its final cycle.
// ---------------------------------------------------------------------------
module stationary_track_detector_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [2:0] track_id, [18:3] x_mm, [34:19] y_mm, [66:35] now_ms, rest zero
    input  logic [71:0] i_s_tdata,
    // [0] op, [1] has_position
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] result_track, [3] stationary, [4] dimmed, [10:5] points_kept
    output logic [15:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import stcd_pkg::*;

    t_state r_state;

    logic [15:0] r_trail, r_window;
    logic [11:0] r_radius;
    logic        r_dim;

    logic [SLOT_W-1:0] r_head [MAX_TRACKS];
    logic [CNT_W-1:0]  r_cnt  [MAX_TRACKS];

    logic [TRK_W-1:0]   r_trk;
    logic               r_op, r_has;
    logic signed [15:0] r_x, r_y;
    logic [31:0]        r_now;
    logic [SLOT_W-1:0]  r_wh;
    logic [CNT_W-1:0]   r_wc;
    logic [CNT_W-1:0]   r_idx;
    logic               r_rd_v, r_old_ok;
    logic signed [20:0] r_sx, r_sy;
    logic [CNT_W-1:0]   r_n;

    logic               r_av, r_bv;
    logic signed [22:0] r_dx, r_dy;
    logic [46:0]        r_d, r_worst;
    logic [16:0]        r_nr;
    logic [33:0]        r_r2;

    logic            r_ov, r_ost, r_odim;
    logic [TRK_W-1:0] r_otrk;
    logic [CNT_W-1:0] r_okept;

    // Point RAM
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [SLOT_W-1:0] rd_slot;

    logic [31:0] rd_time, rd_age;
    logic signed [15:0] rd_x, rd_y;
    logic        in_win;
    logic        full;
    logic [SLOT_W-1:0] app_head;
    logic [CNT_W-1:0]  app_cnt;
    logic        want_append;
    logic        shift;
    t_pt         load_pt;
    t_pt         chain [MAX_POINTS];
    t_pt         tail;
    logic        stationary;
    logic        out_free;

    assign rd_time = ram_rdata[63:32];
    assign rd_x    = ram_rdata[31:16];
    assign rd_y    = ram_rdata[15:0];
    assign rd_age  = r_now - rd_time;
    assign in_win  = r_rd_v && (rd_age <= {16'd0, r_window});

    assign full     = (r_wc == CNT_W'(MAX_POINTS));
    assign app_head = full ? r_wh + SLOT_W'(1) : r_wh;
    assign app_cnt  = full ? CNT_W'(MAX_POINTS - 1) : r_wc;
    assign want_append = (r_op == OP_REPORT) && r_has;

    always_comb begin
        case (r_state)
            ST_PRUNE_RD: rd_slot = r_wh;
            ST_DUP_RD:   rd_slot = r_wh + r_wc[SLOT_W-1:0] - SLOT_W'(1);
            default:     rd_slot = r_wh + r_idx[SLOT_W-1:0];
        endcase
    end

    assign ram_raddr = {r_trk, rd_slot};
    assign ram_we    = (r_state == ST_APPEND);
    assign ram_waddr = {r_trk, app_head + app_cnt[SLOT_W-1:0]};

    stcd_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_now, r_x, r_y}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Chain of cells: filled from the RAM, then drained into the spread pipeline.
    assign shift = ((r_state == ST_LOAD) && (r_idx != '0))
                || ((r_state == ST_DRAIN) && (r_idx < CNT_W'(MAX_POINTS)));
    assign load_pt.x   = rd_x;
    assign load_pt.y   = rd_y;
    assign load_pt.win = (r_state == ST_LOAD) && in_win;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
            stcd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_pt    ((gi == 0) ? load_pt : chain[(gi == 0) ? 0 : gi - 1]),
                .o_pt    (chain[gi])
            );
        end
    endgenerate

    assign tail = chain[MAX_POINTS-1];

    assign stationary = r_old_ok && (r_n != '0) && (r_worst <= {13'd0, r_r2});
    assign out_free   = !r_ov || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trail  <= 16'd3000;
            r_window <= 16'd2000;
            r_radius <= 12'd150;
            r_dim    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TRAIL:  r_trail  <= i_cfg_data;
                CFG_WINDOW: r_window <= i_cfg_data;
                CFG_RADIUS: r_radius <= i_cfg_data[11:0];
                CFG_DIM:    r_dim    <= i_cfg_data[0];
                default:    r_dim    <= r_dim;
            endcase
        end
    end

    // Spread pipeline: difference from centroid, squared distance, running max.
    always_ff @(posedge i_clk) begin
        r_dx <= 23'($signed({1'b0, r_n})) * 23'($signed(tail.x)) - 23'(r_sx);
        r_dy <= 23'($signed({1'b0, r_n})) * 23'($signed(tail.y)) - 23'(r_sy);
        r_nr <= 17'(r_n) * 17'(r_radius);
        r_d  <= 47'($unsigned(46'(r_dx) * 46'(r_dx)))
              + 47'($unsigned(46'(r_dy) * 46'(r_dy)));
        r_r2 <= {17'd0, r_nr} * {17'd0, r_nr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_av    <= 1'b0;
            r_bv    <= 1'b0;
            for (int t = 0; t < MAX_TRACKS; t++) begin
                r_head[t] <= '0;
                r_cnt[t]  <= '0;
            end
        end else begin
            if (r_ov && i_m_tready && (r_state != ST_FIN)) begin
                r_ov <= 1'b0;
            end
            r_av <= (r_state == ST_DRAIN) && (r_idx < CNT_W'(MAX_POINTS)) && tail.win;
            r_bv <= r_av;
            if ((r_state == ST_LOAD) && (r_idx == '0)) begin
                r_worst <= '0;
            end else if (r_bv && (r_d > r_worst)) begin
                r_worst <= r_d;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_trk   <= i_s_tdata[2:0];
                        r_x     <= i_s_tdata[18:3];
                        r_y     <= i_s_tdata[34:19];
                        r_now   <= i_s_tdata[66:35];
                        r_op    <= i_s_tuser[0];
                        r_has   <= i_s_tuser[1];
                        r_wh    <= r_head[i_s_tdata[2:0]];
                        r_wc    <= r_cnt[i_s_tdata[2:0]];
                        r_state <= ST_PRUNE_RD;
                    end
                end
                ST_PRUNE_RD: begin
                    r_idx <= '0;
                    if (r_wc != '0) begin
                        r_state <= ST_PRUNE_CK;
                    end else if (want_append) begin
                        r_state <= ST_APPEND;
                    end else begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_PRUNE_CK: begin
                    if (rd_age > {16'd0, r_trail}) begin
                        r_wh    <= r_wh + SLOT_W'(1);
                        r_wc    <= r_wc - CNT_W'(1);
                        r_state <= ST_PRUNE_RD;
                    end else if (want_append) begin
                        r_state <= ST_DUP_RD;
                    end else begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_DUP_RD: begin
                    r_state <= ST_DUP_CK;
                end
                ST_DUP_CK: begin
                    if ((rd_x == r_x) && (rd_y == r_y)) begin
                        r_state <= ST_LOAD;
                    end else begin
                        r_state <= ST_APPEND;
                    end
                end
                ST_APPEND: begin
                    r_wh    <= app_head;
                    r_wc    <= app_cnt + CNT_W'(1);
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_rd_v <= (r_idx < CNT_W'(MAX_POINTS)) && (r_idx < r_wc);
                    if (r_idx == '0) begin
                        r_sx     <= '0;
                        r_sy     <= '0;
                        r_n      <= '0;
                        r_old_ok <= 1'b0;
                    end else begin
                        // The first slot loaded is the oldest kept point.
                        if (r_idx == CNT_W'(1)) begin
                            r_old_ok <= r_rd_v && (rd_age >= {16'd0, r_window});
                        end
                        if (in_win) begin
                            r_sx <= r_sx + 21'(rd_x);
                            r_sy <= r_sy + 21'(rd_y);
                            r_n  <= r_n + CNT_W'(1);
                        end
                    end
                    if (r_idx == CNT_W'(MAX_POINTS)) begin
                        r_idx   <= '0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                ST_DRAIN: begin
                    r_idx <= r_idx + CNT_W'(1);
                    if (r_idx == CNT_W'(MAX_POINTS + 2)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_head[r_trk] <= r_wh;
                        r_cnt[r_trk]  <= r_wc;
                        r_ov    <= 1'b1;
                        r_otrk  <= r_trk;
                        r_ost   <= stationary;
                        r_odim  <= stationary && r_dim;
                        r_okept <= r_wc;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {5'd0, r_okept, r_odim, r_ost, r_otrk};
endmodule
